/* design/nand_hamming_ecc_512_core_defines.svh */
// assertion macros used by the checker file
`ifndef NAND_HAMMING_ECC_512_CORE_DEFINES_SVH
`define NAND_HAMMING_ECC_512_CORE_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define NHECC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked implication, off while reset is asserted
`define NHECC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/nhecc_pkg.sv */
// shared widths, codes and defaults of the nand hamming ecc core
package nhecc_pkg;

  localparam int unsigned DefaultBlockBytes = 512;

  localparam int unsigned DataWidth    = 8;
  localparam int unsigned CodeWidth    = 24;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned ErrByteWidth = 9;
  localparam int unsigned ErrBitWidth  = 3;
  localparam int unsigned CountWidth   = 5;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk      = 2'd0,
    StatusSingle  = 2'd1,
    StatusCodeBit = 2'd2,
    StatusMulti   = 2'd3
  } status_e;

  localparam logic CmdGenerate = 1'b0;
  localparam logic CmdCheck    = 1'b1;

  function automatic logic [3:0] popcount8(logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, v[k]};
    end
    return n;
  endfunction

endpackage

/* design/nand_hamming_ecc_512_core.sv */
// one-bit-correcting hamming ecc over a nand data block, one byte per cycle unless stalled
//
// input channel: one transaction per data byte, in address order, with last_i
// on the final byte of the block. command_i and stored_code_i matter only on
// the last byte: generate returns the code, check also compares it with the
// stored code and reports the error class and the bit to flip.
// output channel: one transaction per block, carrying code, status and the
// byte and bit to correct.
// throughput: one byte per cycle, back to back, while in_ready_o is high, with blocks
// following each other without a gap.
// result path: the code is formed from the accumulators in the accept cycle
// and held in the stage register; the syndrome popcount and classification
// are formed from it and registered in the result register.
// stalls: a finished code waits in a stage register while the result
// register is held; bytes are still taken while only one of the two is full.
// reset: asynchronous, clears the byte counter, both accumulators and the
// valid flags; the first byte can be taken in the first cycle after reset.
module nand_hamming_ecc_512_core #(
  parameter int unsigned BLOCK_BYTES = nhecc_pkg::DefaultBlockBytes
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [nhecc_pkg::DataWidth-1:0]    data_byte_i,
  input  logic                               last_i,
  input  logic                               command_i,
  input  logic [nhecc_pkg::CodeWidth-1:0]    stored_code_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [nhecc_pkg::CodeWidth-1:0]    code_o,
  output logic [nhecc_pkg::StatusWidth-1:0]  status_o,
  output logic [nhecc_pkg::ErrByteWidth-1:0] error_byte_o,
  output logic [nhecc_pkg::ErrBitWidth-1:0]  error_bit_o
);
  import nhecc_pkg::*;

  localparam int unsigned ParW   = $clog2(8 * BLOCK_BYTES + 1) - 1;
  localparam int unsigned CntW   = ParW - 3;
  localparam int unsigned FullW  = 2 * ParW;
  localparam logic [ErrByteWidth-1:0] ByteMask = ErrByteWidth'((BLOCK_BYTES - 1) & 511);
  localparam logic [CountWidth-1:0]   ParCount = CountWidth'(ParW);

  logic            in_xfer;
  logic            out_free;
  logic            s1_free;

  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic [ParW-1:0] odd_q, odd_d;
  logic [ParW-1:0] even_q, even_d;
  logic [ParW-1:0] odd_delta, even_delta, odd_next, even_next;
  logic [2:0]      low_xor;
  logic            byte_par;
  logic [FullW-1:0] code_full;

  logic                 s1_valid_q;
  logic [CodeWidth-1:0] s1_code_q;
  logic                 s1_cmd_q;
  logic [CodeWidth-1:0] s1_stored_q;

  logic [CodeWidth-1:0]  synd;
  logic [CountWidth-1:0] ones;
  status_e               status_d;
  logic [ErrByteWidth-1:0] ebyte_d;
  logic [ErrBitWidth-1:0]  ebit_d;

  logic                    out_valid_q;
  logic [CodeWidth-1:0]    code_q;
  status_e                 status_q;
  logic [ErrByteWidth-1:0] ebyte_q;
  logic [ErrBitWidth-1:0]  ebit_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_ready_o = s1_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // parity contribution of one byte
  always_comb begin
    low_xor = '0;
    for (int k = 0; k < 8; k++) begin
      if (data_byte_i[k]) begin
        low_xor = low_xor ^ 3'(k);
      end
    end
  end

  assign byte_par   = ^data_byte_i;
  assign odd_delta  = (byte_par ? {byte_count_q, 3'b000} : '0) | {{CntW{1'b0}}, low_xor};
  assign even_delta = odd_delta ^ (byte_par ? {ParW{1'b1}} : '0);
  assign odd_next   = odd_q ^ odd_delta;
  assign even_next  = even_q ^ even_delta;
  assign code_full  = {~even_next, ~odd_next};

  always_comb begin
    byte_count_d = byte_count_q;
    odd_d        = odd_q;
    even_d       = even_q;
    if (in_xfer) begin
      if (last_i) begin
        byte_count_d = '0;
        odd_d        = '0;
        even_d       = '0;
      end else begin
        byte_count_d = byte_count_q + 1'b1;
        odd_d        = odd_next;
        even_d       = even_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      odd_q        <= '0;
      even_q       <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      odd_q        <= odd_d;
      even_q       <= even_d;
      if (in_xfer && last_i) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_i) begin
      s1_code_q   <= CodeWidth'(code_full);
      s1_cmd_q    <= command_i;
      s1_stored_q <= stored_code_i;
    end
  end

  // syndrome classification
  assign synd = s1_code_q ^ s1_stored_q;
  assign ones = CountWidth'(popcount8(synd[7:0])) + CountWidth'(popcount8(synd[15:8]))
              + CountWidth'(popcount8(synd[23:16]));

  always_comb begin
    status_d = StatusOk;
    ebyte_d  = '0;
    ebit_d   = '0;
    if (s1_cmd_q == CmdCheck) begin
      if (ones == '0) begin
        status_d = StatusOk;
      end else if (ones == ParCount) begin
        status_d = StatusSingle;
        ebyte_d  = synd[ErrBitWidth +: ErrByteWidth] & ByteMask;
        ebit_d   = synd[ErrBitWidth-1:0];
      end else if (ones == CountWidth'(1)) begin
        status_d = StatusCodeBit;
      end else begin
        status_d = StatusMulti;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      code_q   <= s1_code_q;
      status_q <= status_d;
      ebyte_q  <= ebyte_d;
      ebit_q   <= ebit_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_o       = code_q;
  assign status_o     = status_q;
  assign error_byte_o = ebyte_q;
  assign error_bit_o  = ebit_q;

endmodule

/* design/nhecc_checker.sv */
// port-level checks of the nand hamming ecc core, bound to the core module
`include "nand_hamming_ecc_512_core_defines.svh"

module nhecc_checker #(
  parameter int unsigned BLOCK_BYTES = nhecc_pkg::DefaultBlockBytes
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [nhecc_pkg::DataWidth-1:0]    data_byte_i,
  input logic                               last_i,
  input logic                               command_i,
  input logic [nhecc_pkg::CodeWidth-1:0]    stored_code_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [nhecc_pkg::CodeWidth-1:0]    code_o,
  input logic [nhecc_pkg::StatusWidth-1:0]  status_o,
  input logic [nhecc_pkg::ErrByteWidth-1:0] error_byte_o,
  input logic [nhecc_pkg::ErrBitWidth-1:0]  error_bit_o
);
  import nhecc_pkg::*;

  localparam logic [ErrByteWidth-1:0] ByteMask = ErrByteWidth'((BLOCK_BYTES - 1) & 511);

  logic unused_ok;
  assign unused_ok = ^{data_byte_i, command_i, stored_code_i};

  // result holds until taken
  `NHECC_ASSERT_IMPL(a_out_hold, out_valid_o && !out_ready_i,
    ##1 (out_valid_o && $stable(code_o) && $stable(status_o)), "result dropped or changed")

  // a new result comes only from an accepted last byte
  `NHECC_ASSERT_IMPL(a_out_after_last, $rose(out_valid_o),
    $past(in_valid_i && in_ready_o && last_i, 2), "result without a last byte")

  // input stalls only while a result is stalled
  `NHECC_ASSERT_IMPL(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i,
    "input stalled with free output")

  // flip location only reported for a single data error, inside the block
  `NHECC_ASSERT_IMPL(a_err_loc, out_valid_o,
    (status_o == StatusSingle) ? ((error_byte_o & ~ByteMask) == '0)
                               : (error_byte_o == '0 && error_bit_o == '0),
    "bad error location")

endmodule

bind nand_hamming_ecc_512_core nhecc_checker #(.BLOCK_BYTES(BLOCK_BYTES)) u_nhecc_checker (.*);
